/* src/dweh_pkg.sv */
// Shared types and constants for the DWARF EH pointer decoder.
// No dependencies; imported by dwarf_eh_pointer_decoder and its testbench.
`timescale 1ns / 1ps

package dweh_pkg;

	// Format nibble codes
	localparam logic [3:0] FMT_ABSPTR  = 4'h0;
	localparam logic [3:0] FMT_ULEB128 = 4'h1;
	localparam logic [3:0] FMT_UDATA2  = 4'h2;
	localparam logic [3:0] FMT_UDATA4  = 4'h3;
	localparam logic [3:0] FMT_UDATA8  = 4'h4;
	localparam logic [3:0] FMT_SLEB128 = 4'h9;
	localparam logic [3:0] FMT_SDATA2  = 4'ha;
	localparam logic [3:0] FMT_SDATA4  = 4'hb;
	localparam logic [3:0] FMT_SDATA8  = 4'hc;

	// Application field (encoding bits 6:4)
	localparam logic [2:0] APPL_PCREL = 3'h1;

	// LEB byte fields
	localparam int LEB_MORE_BIT = 7;
	localparam int LEB_SIGN_BIT = 6;

	localparam logic [3:0] BYTE_COUNT_MAX = 4'hf;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_BAD_FMT = 1'b1;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [7:0]  encoding;
		logic        value_start;
		logic [31:0] value_offset;
	} dweh_in_t;

	typedef struct packed {
		logic [63:0] value;
		logic [3:0]  byte_count;
		logic        status;
		logic        byte_used;
	} dweh_out_t;

	// Byte length of a fixed-size format; 0 for LEB and unknown formats.
	function automatic logic [3:0] fixed_length(input logic [3:0] fmt);
		logic [3:0] len;
		begin
			unique case (fmt)
				FMT_ABSPTR, FMT_UDATA8, FMT_SDATA8: len = 4'd8;
				FMT_UDATA2, FMT_SDATA2:             len = 4'd2;
				FMT_UDATA4, FMT_SDATA4:             len = 4'd4;
				default:                            len = 4'd0;
			endcase
			return len;
		end
	endfunction

	function automatic logic is_leb(input logic [3:0] fmt);
		return (fmt == FMT_ULEB128) || (fmt == FMT_SLEB128);
	endfunction

	function automatic logic format_known(input logic [3:0] fmt);
		return is_leb(fmt) || (fixed_length(fmt) != 4'd0);
	endfunction

endpackage

/* src/dwarf_eh_pointer_decoder.sv */
// DWARF exception-handling encoded-pointer decoder, one byte per word.
// Depends on dweh_pkg (types, format codes, length function).
//
// Usage:
//  - Input channel (in_valid/in_stall/in_word): one raw byte per word. The
//    first byte of a value has value_start set and carries the encoding byte
//    and the section offset of that byte; both are ignored on later bytes.
//  - Output channel (out_valid/out_stall/out_word): one word per completed
//    value, or one at once for a start byte with an unsupported format
//    (status 1, value 0, byte_count 0, byte_used 0). Partial values give
//    nothing; a new start mid-value drops the partial value silently.
//  - cfg_we/cfg_wdata load section_address, added (with the offset) to
//    pc-relative values. Write it only while the decoder is idle.
// Timing: one input word per cycle sustained while out_stall does not hold the output. A word
//  passes the input register, then is decoded into the output register that drives out_valid.
//  Per byte: one shift/OR into the accumulator, the sign fill, and a
//  three-operand 64-bit add for the pc-relative adjustment.
// Stall: when out_valid is high and out_stall holds it, the input register
//  stops draining and in_stall rises in the same cycle; no word is lost.
// Reset: arst_n clears all valids, the decode state and section_address.
`timescale 1ns / 1ps

module dwarf_eh_pointer_decoder
	import dweh_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  dweh_in_t  in_word,
	output logic      out_valid,
	input  logic      out_stall,
	output dweh_out_t out_word,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata
);

	// Config
	logic [63:0] section_address_q;

	// Input register
	logic     valid_s1;
	dweh_in_t word_s1;

	// Decode state
	logic [63:0] acc_q;
	logic [6:0]  shift_q;
	logic [3:0]  seen_q;
	logic [7:0]  held_enc_q;
	logic [31:0] held_off_q;
	logic        in_value_q;

	// Output register
	logic      out_valid_q;
	dweh_out_t out_q;

	// Handshake
	logic out_free;
	logic advance;
	logic take_in;

	// Decode datapath
	logic        start;
	logic        active;
	logic        known;
	logic [7:0]  enc;
	logic [31:0] off;
	logic [3:0]  fmt;
	logic [63:0] acc0;
	logic [6:0]  shift0;
	logic [3:0]  seen0;
	logic [63:0] acc1;
	logic [6:0]  shift1;
	logic [3:0]  seen1;
	logic [2:0]  pos;
	logic        done;
	logic [63:0] value_adj;
	logic        emit;
	dweh_out_t   res;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign take_in  = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			section_address_q <= '0;
		end else if (cfg_we) begin
			section_address_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			word_s1 <= in_word;
		end
	end

	// Pick the working state: fresh on a start byte, held otherwise.
	always_comb begin
		start  = word_s1.value_start;
		enc    = start ? word_s1.encoding : held_enc_q;
		off    = start ? word_s1.value_offset : held_off_q;
		acc0   = start ? 64'd0 : acc_q;
		shift0 = start ? 7'd0 : shift_q;
		seen0  = start ? 4'd0 : seen_q;
		fmt    = enc[3:0];
		known  = format_known(fmt);
		active = start ? known : in_value_q;
	end

	// One byte of accumulation.
	always_comb begin
		seen1  = (seen0 == BYTE_COUNT_MAX) ? BYTE_COUNT_MAX : seen0 + 4'd1;
		pos    = seen0[2:0];
		acc1   = acc0;
		shift1 = shift0;
		done   = 1'b0;
		if (is_leb(fmt)) begin
			if (!shift0[6]) begin
				acc1   = acc0 | ({57'd0, word_s1.data_byte[6:0]} << shift0[5:0]);
				shift1 = shift0 + 7'd7;
			end
			done = !word_s1.data_byte[LEB_MORE_BIT];
			// Sign fill only while the final shift is below 64
			if (done && fmt == FMT_SLEB128 && word_s1.data_byte[LEB_SIGN_BIT]
					&& !shift1[6]) begin
				acc1 = acc1 | (~64'd0 << shift1[5:0]);
			end
		end else begin
			acc1 = acc0 | ({56'd0, word_s1.data_byte} << {pos, 3'b000});
			done = (seen1 >= fixed_length(fmt));
			if (done && fmt == FMT_SDATA2 && acc1[15]) begin
				acc1 = acc1 | {48'hffff_ffff_ffff, 16'd0};
			end
			if (done && fmt == FMT_SDATA4 && acc1[31]) begin
				acc1 = acc1 | {32'hffff_ffff, 32'd0};
			end
		end
	end

	always_comb begin
		value_adj = acc1;
		if (enc[6:4] == APPL_PCREL) begin
			value_adj = acc1 + section_address_q + {32'd0, off};
		end
		emit = 1'b0;
		res  = '0;
		if (start && !known) begin
			emit           = 1'b1;
			res.value      = '0;
			res.byte_count = '0;
			res.status     = STATUS_BAD_FMT;
			res.byte_used  = 1'b0;
		end else if (active && done) begin
			emit           = 1'b1;
			res.value      = value_adj;
			res.byte_count = seen1;
			res.status     = STATUS_OK;
			res.byte_used  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			shift_q    <= '0;
			seen_q     <= '0;
			held_enc_q <= '0;
			held_off_q <= '0;
			in_value_q <= 1'b0;
		end else if (advance) begin
			if (start) begin
				held_enc_q <= word_s1.encoding;
				held_off_q <= word_s1.value_offset;
			end
			if (active) begin
				acc_q   <= acc1;
				shift_q <= shift1;
				seen_q  <= seen1;
			end
			in_value_q <= active && !done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= res;
		end
	end

	// A format error never reports consumed bytes.
	a_bad_fmt_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == STATUS_BAD_FMT
			|-> !out_q.byte_used && out_q.byte_count == 4'd0)
		else $error("format error result carries bytes");

	// A decoded value always consumed at least one byte.
	a_used_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.byte_used |-> out_q.byte_count != 4'd0)
		else $error("decoded value with zero byte count");

	// A value in progress always has a supported format.
	a_inval_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_value_q |-> format_known(held_enc_q[3:0]))
		else $error("value in progress with unsupported format");

	// LEB shift stops growing past 70.
	a_shift_bound: assert property (@(posedge clk) disable iff (!arst_n)
		shift_q <= 7'd70)
		else $error("LEB shift out of range");

	// A result held under stall is not overwritten.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(out_q))
		else $error("stalled result changed");

endmodule

/* verif/dwarf_eh_pointer_decoder_tb.sv */
// Self-checking testbench for dwarf_eh_pointer_decoder: a directed then random byte stream of
// encoded pointers is checked word by word against an in-bench decoder model.
// Depends on dweh_pkg (word structs, format and field codes) and the decoder RTL.
`timescale 1ns / 1ps

module dwarf_eh_pointer_decoder_tb
	import dweh_pkg::*;
();

	localparam int CYCLE_LIMIT  = 1_000_000;
	// Input and output registers plus slack, so a word that gives no result has left the block.
	localparam int DRAIN_CYCLES = 8;

	localparam logic [3:0] KNOWN_FMTS [9] = '{
		FMT_ABSPTR, FMT_ULEB128, FMT_UDATA2, FMT_UDATA4, FMT_UDATA8,
		FMT_SLEB128, FMT_SDATA2, FMT_SDATA4, FMT_SDATA8
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	dweh_in_t    in_word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	dweh_out_t   out_word;
	logic        cfg_we = 1'b0;
	logic [63:0] cfg_wdata = '0;

	dwarf_eh_pointer_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Words waiting to be driven, and decoded pointers waiting to come out.
	dweh_in_t  pending_words [$];
	dweh_out_t expected_words [$];

	int          fail_count = 0;
	int unsigned cycle_count = 0;
	bit          in_gaps = 1'b1;
	bit          out_stalls = 1'b1;
	bit          word_taken = 1'b0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;

	// Decoder model state; section_addr mirrors the one config register.
	logic [63:0] section_addr = '0;
	logic [63:0] dec_acc = '0;
	logic [6:0]  dec_shift = '0;
	logic [3:0]  dec_count = '0;
	logic [7:0]  dec_enc = '0;
	logic [31:0] dec_off = '0;
	logic        dec_busy = 1'b0;

	// Byte length of a fixed-size format; 0 for LEB and for unsupported nibbles.
	function automatic int fixed_bytes(input logic [3:0] fmt);
		case (fmt)
			FMT_ABSPTR, FMT_UDATA8, FMT_SDATA8: return 8;
			FMT_UDATA2, FMT_SDATA2:             return 2;
			FMT_UDATA4, FMT_SDATA4:             return 4;
			default:                            return 0;
		endcase
	endfunction

	function automatic logic leb_format(input logic [3:0] fmt);
		return (fmt == FMT_ULEB128) || (fmt == FMT_SLEB128);
	endfunction

	// Mostly short, now and then long.
	function automatic int unsigned next_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Advance the model by one accepted byte; queue the decoded pointer if any.
	task automatic decode_byte(input dweh_in_t w);
		logic [3:0]  fmt;
		logic [2:0]  pos;
		logic [63:0] ptr;
		logic        done;
		dweh_out_t   r;
		done = 1'b0;
		r = '0;
		if (w.value_start) begin
			dec_enc   = w.encoding;
			dec_off   = w.value_offset;
			dec_acc   = '0;
			dec_shift = '0;
			dec_count = '0;
			dec_busy  = 1'b0;
			if (!leb_format(w.encoding[3:0]) && fixed_bytes(w.encoding[3:0]) == 0) begin
				// unsupported nibble: flagged at once, nothing consumed
				r.status = STATUS_BAD_FMT;
				expected_words = {expected_words, r};
				return;
			end
			dec_busy = 1'b1;
		end else if (!dec_busy) begin
			return;
		end

		fmt = dec_enc[3:0];
		if (dec_count != BYTE_COUNT_MAX)
			dec_count = dec_count + 4'd1;

		if (leb_format(fmt)) begin
			// payload past bit 63 is dropped; shift parks at 70
			if (dec_shift < 7'd64) begin
				dec_acc   = dec_acc | ({57'b0, w.data_byte[6:0]} << dec_shift);
				dec_shift = dec_shift + 7'd7;
			end
			if (!w.data_byte[LEB_MORE_BIT]) begin
				done = 1'b1;
				if (fmt == FMT_SLEB128 && w.data_byte[LEB_SIGN_BIT] && dec_shift < 7'd64)
					dec_acc = dec_acc | ({64{1'b1}} << dec_shift);
			end
		end else begin
			pos = 3'(dec_count - 4'd1);
			dec_acc = dec_acc | ({56'b0, w.data_byte} << {pos, 3'b000});
			if (int'(dec_count) >= fixed_bytes(fmt)) begin
				done = 1'b1;
				if (fmt == FMT_SDATA2 && dec_acc[15])
					dec_acc[63:16] = '1;
				if (fmt == FMT_SDATA4 && dec_acc[31])
					dec_acc[63:32] = '1;
			end
		end

		if (done) begin
			ptr = dec_acc;
			if (dec_enc[6:4] == APPL_PCREL)
				ptr = ptr + section_addr + {32'b0, dec_off};
			r.value      = ptr;
			r.byte_count = dec_count;
			r.status     = STATUS_OK;
			r.byte_used  = 1'b1;
			expected_words = {expected_words, r};
			dec_busy = 1'b0;
		end
	endtask

	// Continuation bytes get random encoding and offset: the block must ignore them.
	task automatic add_word(input logic first, input logic [7:0] enc, input logic [31:0] off,
			input logic [7:0] data);
		dweh_in_t w;
		w.data_byte    = data;
		w.value_start  = first;
		w.encoding     = first ? enc : 8'($urandom);
		w.value_offset = first ? off : $urandom;
		pending_words = {pending_words, w};
	endtask

	// Up to 8 bytes taken little-endian from a packed vector.
	task automatic add_value(input logic [7:0] enc, input logic [31:0] off,
			input logic [63:0] bytes, input int n);
		for (int i = 0; i < n; i++)
			add_word(i == 0, enc, off, bytes[8*i +: 8]);
	endtask

	// Sender has run dry and every expected word is back; then let the pipe empty.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_words.size() != 0 || in_valid || expected_words.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_section(input logic [63:0] addr);
		wait_idle();
		@(negedge clk);
		cfg_we       <= 1'b1;
		cfg_wdata    <= addr;
		section_addr = addr;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random stream: mostly whole values, some idle noise, unsupported nibbles,
	// and values cut short by a fresh start.
	task automatic run_phase(input logic [63:0] addr, input int n_words, input bit gaps,
			input bit stalls);
		int          made;
		int          len;
		int          sent;
		int unsigned pick;
		int unsigned lr;
		bit          broken;
		logic [7:0]  enc;
		logic [7:0]  data;
		logic [31:0] off;
		set_section(addr);
		in_gaps    = gaps;
		out_stalls = stalls;
		made       = 0;
		while (made < n_words) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				// stray byte while idle: ignored, not counted
				add_word(1'b0, 8'h00, 32'h0, 8'($urandom));
			end else if (pick < 10) begin
				enc = 8'($urandom);
				do
					enc[3:0] = 4'($urandom);
				while (leb_format(enc[3:0]) || fixed_bytes(enc[3:0]) != 0);
				add_word(1'b1, enc, $urandom, 8'($urandom));
				made++;
			end else begin
				broken = (pick < 16);
				for (int pass = 0; pass <= int'(broken); pass++) begin
					enc      = 8'($urandom);
					enc[3:0] = KNOWN_FMTS[$urandom_range(0, 8)];
					if ($urandom_range(0, 4) < 2)
						enc[6:4] = APPL_PCREL;
					case ($urandom_range(0, 7))
						0:       off = '0;
						1:       off = '1;
						default: off = $urandom;
					endcase
					len = fixed_bytes(enc[3:0]);
					if (leb_format(enc[3:0])) begin
						lr = $urandom_range(0, 99);
						if (lr < 60)
							len = $urandom_range(1, 3);
						else if (lr < 90)
							len = $urandom_range(4, 10);
						else
							len = $urandom_range(11, 18);  // overlong, count saturates above 15
						if (len < 2)
							len = 2;
					end
					sent = (broken && pass == 0) ? int'($urandom_range(1, len - 1)) : len;
					for (int i = 0; i < sent; i++) begin
						case ($urandom_range(0, 7))
							0:       data = 8'h00;
							1:       data = 8'hff;
							default: data = 8'($urandom);
						endcase
						if (leb_format(enc[3:0]))
							data[LEB_MORE_BIT] = (i < len - 1);
						add_word(i == 0, enc, off, data);
					end
					made += sent;
				end
			end
		end
	endtask

	// Input side: a word is taken at a rising edge with valid high and stall low.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			decode_byte(in_word);
			word_taken = 1'b1;
		end
	end

	// Driver: changes on the falling edge, holds a stalled word unchanged.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || word_taken)) begin
			word_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				in_word  <= pending_words.pop_front();
				in_valid <= 1'b1;
				gap_left = in_gaps ? next_gap() : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output back-pressure: random runs of stall.
	always @(negedge clk) begin
		if (stall_left == 0 && out_stalls && $urandom_range(0, 3) == 0)
			stall_left = next_gap() + 1;
		out_stall <= (stall_left != 0);
		if (stall_left != 0)
			stall_left--;
	end

	// Monitor: every word out is matched against the oldest expectation.
	always @(posedge clk) begin
		dweh_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected word: value=%h count=%0d status=%0b used=%0b",
						out_word.value, out_word.byte_count, out_word.status,
						out_word.byte_used);
			end else begin
				want = expected_words.pop_front();
				if (out_word.value !== want.value || out_word.byte_count !== want.byte_count ||
						out_word.status !== want.status ||
						out_word.byte_used !== want.byte_used) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: exp value=%h count=%0d status=%0b used=%0b / %s",
							want.value, want.byte_count, want.status, want.byte_used,
							$sformatf("got value=%h count=%0d status=%0b used=%0b",
								out_word.value, out_word.byte_count, out_word.status,
								out_word.byte_used));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: all-ones section address so pc-relative sums wrap.
		set_section('1);
		add_word(1'b1, 8'h95, 32'hffff_ffff, 8'h00);     // unsupported nibble, pcrel ignored
		add_word(1'b0, 8'h00, 32'h0, 8'hff);             // idle byte, dropped
		add_value(8'h01, 32'h0, 64'h8080, 2);            // partial uleb, abandoned by restart
		add_value(8'h01, 32'h0, 64'h7f, 1);              // largest one-byte uleb
		add_value(8'h09, 32'h1234, 64'h40, 1);           // sleb sign bit -> -64
		add_value(8'h02, 32'h0, 64'hffff, 2);            // udata2 max
		add_value(8'h1a, 32'hffff_ffff, 64'h8000, 2);    // sdata2 negative, pcrel
		add_value(8'hfb, 32'h0, 64'h8000_0000, 4);       // sdata4 negative, indirect set
		add_value(8'h10, 32'hffff_ffff, '1, 8);          // absptr all ones, pcrel wraps

		// Random phases, pausing for a full drain before each register write.
		run_phase(64'h0, 370, 1'b0, 1'b0);
		run_phase({$urandom, $urandom}, 370, 1'b1, 1'b1);
		run_phase(64'h8000_0000_0000_0000, 370, 1'b1, 1'b1);
		run_phase(64'h1, 370, 1'b1, 1'b0);
		run_phase({$urandom, $urandom}, 370, 1'b0, 1'b1);

		wait_idle();
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* dwarf_eh_pointer_decoder.f */
src/dweh_pkg.sv
src/dwarf_eh_pointer_decoder.sv
verif/dwarf_eh_pointer_decoder_tb.sv
